// ===== rtl/bcm_pkg.sv =====
`timescale 1ns / 1ps

package bcm_pkg;

   localparam int TIME_BITS      = 32;
   localparam int TIME_CNT_BITS  = $clog2(TIME_BITS);
   localparam int INTERVAL_BITS  = 32;
   localparam int CFG_BITS       = 8;
   localparam int CSR_INDEX_BITS = 1;
   localparam int MULT_BITS      = 5;

   localparam logic [CFG_BITS-1:0] PULSE_LENGTH_RESET = CFG_BITS'(8);
   localparam logic [CFG_BITS-1:0] TICKS_PER_MS_RESET = CFG_BITS'(20);

   localparam logic [CSR_INDEX_BITS-1:0] CSR_PULSE_LENGTH = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TICKS_PER_MS = CSR_INDEX_BITS'(1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EDGE,
      ST_DIVIDE,
      ST_ELAPSE,
      ST_CHECK,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   // Product of the selected factors 2, 3 and 4; 1 when none is selected.
   function automatic logic [MULT_BITS-1:0] mult_of(input logic two, input logic three,
                                                    input logic four);
      logic [2:0] sel;
      sel = {four, three, two};
      unique case (sel)
         3'b000: mult_of = MULT_BITS'(1);
         3'b001: mult_of = MULT_BITS'(2);
         3'b010: mult_of = MULT_BITS'(3);
         3'b011: mult_of = MULT_BITS'(6);
         3'b100: mult_of = MULT_BITS'(4);
         3'b101: mult_of = MULT_BITS'(8);
         3'b110: mult_of = MULT_BITS'(12);
         3'b111: mult_of = MULT_BITS'(24);
      endcase
   endfunction

endpackage

// ===== rtl/bcm_req_if.sv =====
`timescale 1ns / 1ps

interface bcm_req_if;
   logic valid;
   logic ready;
   logic timer_tick;
   logic clock_in;
   logic sel_times_two;
   logic sel_times_three;
   logic sel_times_four;

   modport source (
      output valid, timer_tick, clock_in, sel_times_two, sel_times_three, sel_times_four,
      input  ready
   );
   modport sink (
      input  valid, timer_tick, clock_in, sel_times_two, sel_times_three, sel_times_four,
      output ready
   );
endinterface

// ===== rtl/bcm_rsp_if.sv =====
`timescale 1ns / 1ps

interface bcm_rsp_if;
   logic                                valid;
   logic                                ready;
   logic                                clock_out;
   logic [bcm_pkg::INTERVAL_BITS-1:0]   interval_ms;

   modport source (
      output valid, clock_out, interval_ms,
      input  ready
   );
   modport sink (
      input  valid, clock_out, interval_ms,
      output ready
   );
endinterface

// ===== rtl/bcm_timebase.sv =====
`timescale 1ns / 1ps

module bcm_timebase (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            step,
   input  logic                            timer_tick,
   input  logic [bcm_pkg::CFG_BITS-1:0]    ticks_per_ms,
   output logic [bcm_pkg::TIME_BITS-1:0]   time_ms
);

   logic [bcm_pkg::CFG_BITS-1:0]  tick_count_ff, tick_count_in;
   logic [bcm_pkg::TIME_BITS-1:0] time_ms_ff, time_ms_in;

   always_comb begin
      tick_count_in = tick_count_ff;
      time_ms_in    = time_ms_ff;
      if (step && timer_tick) begin
         // wrap only on an exact match; a count above the compare runs through 255
         if (tick_count_ff == ticks_per_ms) begin
            tick_count_in = '0;
            time_ms_in    = time_ms_ff + bcm_pkg::TIME_BITS'(1);
         end else begin
            tick_count_in = tick_count_ff + bcm_pkg::CFG_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_count_ff <= '0;
         time_ms_ff    <= '0;
      end else begin
         tick_count_ff <= tick_count_in;
         time_ms_ff    <= time_ms_in;
      end
   end

   assign time_ms = time_ms_ff;

endmodule

// ===== rtl/bcm_serial_div.sv =====
`timescale 1ns / 1ps

module bcm_serial_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [bcm_pkg::TIME_BITS-1:0]   dividend,
   input  logic [bcm_pkg::MULT_BITS-1:0]   divisor,
   output logic [bcm_pkg::TIME_BITS-1:0]   quotient,
   output bcm_pkg::div_status_type         status
);

   logic [bcm_pkg::TIME_BITS-1:0]     quo_ff, quo_in;
   logic [bcm_pkg::MULT_BITS-1:0]     rem_ff, rem_in;
   logic [bcm_pkg::MULT_BITS-1:0]     div_ff, div_in;
   logic [bcm_pkg::TIME_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;
   logic [bcm_pkg::MULT_BITS:0]       trial;
   logic [bcm_pkg::MULT_BITS:0]       diff;
   logic                              fits;

   // Restoring division: one quotient bit per cycle, dividend shifts out MSB first
   // while quotient bits shift in at the bottom of the same register.
   always_comb begin
      trial = {rem_ff, quo_ff[bcm_pkg::TIME_BITS-1]};
      fits  = trial >= {1'b0, div_ff};
      diff  = trial - {1'b0, div_ff};

      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;

      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
         cnt_in  = bcm_pkg::TIME_CNT_BITS'(bcm_pkg::TIME_BITS - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[bcm_pkg::TIME_BITS-2:0], fits};
         rem_in = fits ? diff[bcm_pkg::MULT_BITS-1:0] : trial[bcm_pkg::MULT_BITS-1:0];
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - bcm_pkg::TIME_CNT_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign quotient    = quo_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

   a_done_follows_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff))
      else $error("divider done without a preceding step");

   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("divider started while busy");

   a_done_single: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("divider done held longer than one cycle");

endmodule

// ===== rtl/beat_clock_multiplier_top.sv =====
`timescale 1ns / 1ps

// Beat clock multiplier. Each input item is one sample of the pins: a timer-tick
// strobe, the external clock level and three factor selects. Ticks feed a prescaler
// that advances a wrapping millisecond counter; a rising clock edge measures the time
// since the previous edge and divides it by the selected factor to form the output
// interval, and the output pulses high for pulse_length_ms at that interval. One
// result item comes back per input item. Each item steps through edge, elapse, check
// and result, with a divide step after edge when a rising edge follows an earlier
// nonzero edge time: the division runs in a bit-serial restoring divider, one
// quotient bit per cycle over the 32-bit time word. One item is worked on at a
// time; the result register lets the next item enter while a result waits to be taken.

module beat_clock_multiplier_top (
   input  logic                                 clock,
   input  logic                                 reset,
   bcm_req_if.sink                              req_chan,
   bcm_rsp_if.source                            rsp_chan,
   input  logic                                 csr_we,
   input  logic [bcm_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [bcm_pkg::CFG_BITS-1:0]         csr_wdata
);

   bcm_pkg::state_type              state_ff, state_in;
   logic [bcm_pkg::CFG_BITS-1:0]    plen_ff, plen_in;
   logic [bcm_pkg::CFG_BITS-1:0]    tpm_ff, tpm_in;
   logic                            prev_clk_ff, prev_clk_in;
   logic                            edge_ff, edge_in;
   logic [bcm_pkg::MULT_BITS-1:0]   mult_ff, mult_in;
   logic [bcm_pkg::TIME_BITS-1:0]   last_edge_ff, last_edge_in;
   logic [bcm_pkg::TIME_BITS-1:0]   last_rise_ff, last_rise_in;
   logic [bcm_pkg::TIME_BITS-1:0]   interval_ff, interval_in;
   logic [bcm_pkg::TIME_BITS-1:0]   elapsed_ff, elapsed_in;
   logic                            out_level_ff, out_level_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic                            rsp_clock_out_ff, rsp_clock_out_in;
   logic [bcm_pkg::INTERVAL_BITS-1:0] rsp_interval_ff, rsp_interval_in;

   logic                            accept;
   logic [bcm_pkg::TIME_BITS-1:0]   time_ms;
   logic [bcm_pkg::TIME_BITS-1:0]   dividend;
   logic [bcm_pkg::TIME_BITS-1:0]   quotient;
   logic                            div_start;
   bcm_pkg::div_status_type         div_status;
   logic                            retrig;
   logic                            len_hit;

   assign req_chan.ready = (state_ff == bcm_pkg::ST_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;
   assign dividend       = time_ms - last_edge_ff;

   bcm_timebase u_timebase (
      .clock        (clock),
      .reset        (reset),
      .step         (accept),
      .timer_tick   (req_chan.timer_tick),
      .ticks_per_ms (tpm_ff),
      .time_ms      (time_ms)
   );

   bcm_serial_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend),
      .divisor  (mult_ff),
      .quotient (quotient),
      .status   (div_status)
   );

   always_comb begin
      plen_in = plen_ff;
      tpm_in  = tpm_ff;
      if (csr_we) begin
         unique case (csr_index)
            bcm_pkg::CSR_PULSE_LENGTH: plen_in = csr_wdata;
            bcm_pkg::CSR_TICKS_PER_MS: tpm_in  = csr_wdata;
         endcase
      end
   end

   always_comb begin
      state_in         = state_ff;
      prev_clk_in      = prev_clk_ff;
      edge_in          = edge_ff;
      mult_in          = mult_ff;
      last_edge_in     = last_edge_ff;
      last_rise_in     = last_rise_ff;
      interval_in      = interval_ff;
      elapsed_in       = elapsed_ff;
      out_level_in     = out_level_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_chan.ready;
      rsp_clock_out_in = rsp_clock_out_ff;
      rsp_interval_in  = rsp_interval_ff;
      div_start        = 1'b0;
      retrig           = elapsed_ff >= interval_ff;
      len_hit          = elapsed_ff >= bcm_pkg::TIME_BITS'(plen_ff);

      unique case (state_ff)
         bcm_pkg::ST_IDLE: begin
            if (accept) begin
               edge_in     = req_chan.clock_in && !prev_clk_ff;
               prev_clk_in = req_chan.clock_in;
               mult_in     = bcm_pkg::mult_of(req_chan.sel_times_two,
                                              req_chan.sel_times_three,
                                              req_chan.sel_times_four);
               state_in    = bcm_pkg::ST_EDGE;
            end
         end
         bcm_pkg::ST_EDGE: begin
            state_in = bcm_pkg::ST_ELAPSE;
            if (edge_ff) begin
               last_edge_in = time_ms;
               last_rise_in = time_ms;
               out_level_in = 1'b1;
               // first edge after a zero edge time keeps the interval
               if (last_edge_ff != '0) begin
                  div_start = 1'b1;
                  state_in  = bcm_pkg::ST_DIVIDE;
               end
            end
         end
         bcm_pkg::ST_DIVIDE: begin
            if (div_status.done) begin
               interval_in = quotient;
               state_in    = bcm_pkg::ST_ELAPSE;
            end
         end
         bcm_pkg::ST_ELAPSE: begin
            elapsed_in = time_ms - last_rise_ff;
            state_in   = bcm_pkg::ST_CHECK;
         end
         bcm_pkg::ST_CHECK: begin
            // after a retrigger the time since the rise is zero
            if (retrig) begin
               last_rise_in = time_ms;
               out_level_in = (plen_ff != '0);
            end else if (len_hit) begin
               out_level_in = 1'b0;
            end
            state_in = bcm_pkg::ST_RESULT;
         end
         bcm_pkg::ST_RESULT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in     = 1'b1;
               rsp_clock_out_in = out_level_ff;
               rsp_interval_in  = bcm_pkg::INTERVAL_BITS'(interval_ff);
               state_in         = bcm_pkg::ST_IDLE;
            end
         end
         default: state_in = bcm_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bcm_pkg::ST_IDLE;
         plen_ff      <= bcm_pkg::PULSE_LENGTH_RESET;
         tpm_ff       <= bcm_pkg::TICKS_PER_MS_RESET;
         prev_clk_ff  <= 1'b0;
         edge_ff      <= 1'b0;
         last_edge_ff <= '0;
         last_rise_ff <= '0;
         interval_ff  <= '0;
         out_level_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         plen_ff      <= plen_in;
         tpm_ff       <= tpm_in;
         prev_clk_ff  <= prev_clk_in;
         edge_ff      <= edge_in;
         last_edge_ff <= last_edge_in;
         last_rise_ff <= last_rise_in;
         interval_ff  <= interval_in;
         out_level_ff <= out_level_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mult_ff          <= mult_in;
      elapsed_ff       <= elapsed_in;
      rsp_clock_out_ff <= rsp_clock_out_in;
      rsp_interval_ff  <= rsp_interval_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.clock_out   = rsp_clock_out_ff;
   assign rsp_chan.interval_ms = rsp_interval_ff;

   a_accept_drops_ready: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_chan.ready)
      else $error("second item taken while one is in progress");

   a_div_in_divide: assert property (@(posedge clock) disable iff (reset)
      div_status.busy |-> state_ff == bcm_pkg::ST_DIVIDE)
      else $error("divider running outside the divide step");

   a_zero_length_low: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bcm_pkg::ST_CHECK && plen_ff == '0) |=> !out_level_ff)
      else $error("output high with zero pulse length");

   a_result_held: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bcm_pkg::ST_RESULT && rsp_valid_ff && !rsp_chan.ready)
         |=> state_ff == bcm_pkg::ST_RESULT)
      else $error("result dropped while output register full");

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

typedef struct packed {
   logic tick;
   logic clk_in;
   logic two;
   logic three;
   logic four;
} pin_sample_type;

typedef struct packed {
   logic                              level;
   logic [bcm_pkg::INTERVAL_BITS-1:0] interval;
} out_sample_type;

class beat_tracker;
   logic [bcm_pkg::CFG_BITS-1:0]  pulse_cfg;
   logic [bcm_pkg::CFG_BITS-1:0]  ticks_cfg;
   logic                          prev_level;
   logic [7:0]                    tick_count;
   logic [bcm_pkg::TIME_BITS-1:0] now_ms;
   logic [bcm_pkg::TIME_BITS-1:0] last_edge;
   logic [bcm_pkg::TIME_BITS-1:0] last_rise;
   logic [bcm_pkg::TIME_BITS-1:0] interval;
   logic                          level;
   out_sample_type                pending_outputs[$];
   int                            errors;

   function new();
      pulse_cfg  = bcm_pkg::PULSE_LENGTH_RESET;
      ticks_cfg  = bcm_pkg::TICKS_PER_MS_RESET;
      prev_level = 1'b0;
      tick_count = '0;
      now_ms     = '0;
      last_edge  = '0;
      last_rise  = '0;
      interval   = '0;
      level      = 1'b0;
      errors     = 0;
   endfunction

   function void configure(logic [bcm_pkg::CSR_INDEX_BITS-1:0] idx,
                           logic [bcm_pkg::CFG_BITS-1:0] val);
      if (idx == bcm_pkg::CSR_PULSE_LENGTH) begin
         pulse_cfg = val;
      end else if (idx == bcm_pkg::CSR_TICKS_PER_MS) begin
         ticks_cfg = val;
      end
   endfunction

   // Advance the pin model by one sample and queue the output it produces.
   function void note_sample(pin_sample_type s);
      logic [bcm_pkg::TIME_BITS-1:0] factor;
      logic [bcm_pkg::TIME_BITS-1:0] since;
      out_sample_type                o;
      factor = bcm_pkg::TIME_BITS'(1);
      if (s.tick) begin
         if (tick_count == ticks_cfg) begin
            tick_count = '0;
            now_ms     = now_ms + 1'b1;
         end else begin
            tick_count = tick_count + 1'b1;
         end
      end
      if (s.two)   factor = bcm_pkg::TIME_BITS'(factor * 2);
      if (s.three) factor = bcm_pkg::TIME_BITS'(factor * 3);
      if (s.four)  factor = bcm_pkg::TIME_BITS'(factor * 4);
      if (s.clk_in && !prev_level) begin
         // keep the interval on the first edge, including one at time zero
         if (last_edge != '0) begin
            since    = now_ms - last_edge;
            interval = since / factor;
         end
         last_edge = now_ms;
         last_rise = now_ms;
         level     = 1'b1;
      end
      since = now_ms - last_rise;
      if (since >= interval) begin
         level     = 1'b1;
         last_rise = now_ms;
      end
      since = now_ms - last_rise;
      if (since >= bcm_pkg::TIME_BITS'(pulse_cfg)) level = 1'b0;
      prev_level = s.clk_in;
      o.level    = level;
      o.interval = interval[bcm_pkg::INTERVAL_BITS-1:0];
      pending_outputs.push_back(o);
   endfunction

   function void check_output(out_sample_type got);
      out_sample_type want;
      if (pending_outputs.size() == 0) begin
         $error("unexpected item: clock_out %0d interval_ms %0d", got.level, got.interval);
         errors++;
         return;
      end
      want = pending_outputs.pop_front();
      if (got.level !== want.level) begin
         $error("clock_out: expected %0d, actual %0d", want.level, got.level);
         errors++;
      end
      if (got.interval !== want.interval) begin
         $error("interval_ms: expected %0d, actual %0d", want.interval, got.interval);
         errors++;
      end
   endfunction

   function int pending();
      return pending_outputs.size();
   endfunction
endclass

module tb;
   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASES      = 6;
   localparam int PHASE_PULSE[PHASES] = '{255, 0, 3, 8, 1, 37};
   localparam int PHASE_TICKS[PHASES] = '{0, 1, 0, 20, 255, 2};
   localparam int PHASE_ITEMS[PHASES] = '{100, 80, 120, 80, 80, 250};
   localparam int PHASE_TICK_PCT[PHASES] = '{90, 85, 70, 95, 100, 90};
   localparam int PHASE_NOISE_PCT[PHASES] = '{15, 15, 10, 10, 0, 15};

   logic                               clock;
   logic                               reset;
   logic                               csr_we;
   logic [bcm_pkg::CSR_INDEX_BITS-1:0] csr_index;
   logic [bcm_pkg::CFG_BITS-1:0]       csr_wdata;

   bcm_req_if req_if ();
   bcm_rsp_if rsp_if ();

   beat_tracker tracker = new();
   int          burst_left;

   beat_clock_multiplier_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("tb: FAIL");
      $finish;
   end

   // Write both registers on consecutive edges; the block must be idle.
   task automatic csr_write_both(int pulse, int ticks);
      csr_we    <= 1'b1;
      csr_index <= bcm_pkg::CSR_PULSE_LENGTH;
      csr_wdata <= bcm_pkg::CFG_BITS'(pulse);
      @(posedge clock);
      tracker.configure(bcm_pkg::CSR_PULSE_LENGTH, bcm_pkg::CFG_BITS'(pulse));
      csr_index <= bcm_pkg::CSR_TICKS_PER_MS;
      csr_wdata <= bcm_pkg::CFG_BITS'(ticks);
      @(posedge clock);
      tracker.configure(bcm_pkg::CSR_TICKS_PER_MS, bcm_pkg::CFG_BITS'(ticks));
      csr_we    <= 1'b0;
   endtask

   task automatic send_sample(pin_sample_type s);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 :
               ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 8);
         if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 20);
      end
      burst_left--;
      req_if.valid           <= 1'b1;
      req_if.timer_tick      <= s.tick;
      req_if.clock_in        <= s.clk_in;
      req_if.sel_times_two   <= s.two;
      req_if.sel_times_three <= s.three;
      req_if.sel_times_four  <= s.four;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      tracker.note_sample(s);
   endtask

   // Drop valid and wait until every queued output has come back.
   task automatic drain();
      req_if.valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (tracker.pending() > 0) @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   // Square-wave beats of random shape with random ticks; some items are pure noise.
   task automatic run_beats(int count, int tick_pct, int noise_pct);
      int             sent;
      int             high;
      int             low;
      logic [2:0]     sel;
      pin_sample_type s;
      sent = 0;
      sel  = 3'($urandom_range(0, 7));
      while (sent < count) begin
         high = $urandom_range(1, 6);
         low  = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 10);
         if ($urandom_range(0, 3) == 0) sel = 3'($urandom_range(0, 7));
         for (int i = 0; i < high + low && sent < count; i++) begin
            s.clk_in = (i < high);
            s.tick   = ($urandom_range(0, 99) < tick_pct);
            s.two    = sel[0];
            s.three  = sel[1];
            s.four   = sel[2];
            if ($urandom_range(0, 99) < noise_pct) begin
               s = pin_sample_type'(5'($urandom_range(0, 31)));
            end
            send_sample(s);
            sent++;
         end
      end
   endtask

   initial begin
      int             hold_left;
      int             results_seen;
      int             epoch;
      bit             held_once;
      logic [15:0]    stall_mask;
      out_sample_type got;
      hold_left    = 0;
      results_seen = 0;
      epoch        = 0;
      held_once    = 0;
      stall_mask   = '1;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid && rsp_if.ready) begin
            got.level    = rsp_if.clock_out;
            got.interval = rsp_if.interval_ms;
            tracker.check_output(got);
            results_seen++;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else if (!held_once && results_seen >= 300) begin
            // hold off long enough for the block to back up into its input
            held_once = 1;
            hold_left = 250;
            rsp_if.ready <= 1'b0;
         end else begin
            if (epoch == 0) begin
               epoch      = 64;
               stall_mask = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
            end
            epoch--;
            rsp_if.ready <= stall_mask[0];
            stall_mask = {stall_mask[0], stall_mask[15:1]};
         end
      end
   end

   initial begin
      pin_sample_type s;
      logic [2:0]     sel;
      burst_left             = 0;
      reset                  <= 1'b1;
      csr_we                 <= 1'b0;
      csr_index              <= bcm_pkg::CSR_PULSE_LENGTH;
      csr_wdata              <= '0;
      req_if.valid           <= 1'b0;
      req_if.timer_tick      <= 1'b0;
      req_if.clock_in        <= 1'b0;
      req_if.sel_times_two   <= 1'b0;
      req_if.sel_times_three <= 1'b0;
      req_if.sel_times_four  <= 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: an edge at time zero, a further edge that still counts as the
      // first, then an edge under every select combination.
      csr_write_both(2, 0);
      for (int k = 0; k < 8; k++) begin
         sel      = 3'(k);
         s.two    = sel[0];
         s.three  = sel[1];
         s.four   = sel[2];
         s.tick   = (k != 0);
         s.clk_in = 1'b1;
         send_sample(s);
         s.tick   = 1'b1;
         s.clk_in = 1'b0;
         send_sample(s);
         send_sample(s);
      end
      drain();

      for (int p = 0; p < PHASES; p++) begin
         csr_write_both(PHASE_PULSE[p], PHASE_TICKS[p]);
         run_beats(PHASE_ITEMS[p], PHASE_TICK_PCT[p], PHASE_NOISE_PCT[p]);
         drain();
      end

      if (tracker.errors == 0 && tracker.pending() == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end
endmodule
